### hw/rtl/ptt_pkg.sv
// ptt_pkg: shared constants, codes and types of the pan/tilt target tracker
// no dependencies; imported by every rtl file of the tracker
package ptt_pkg;

	localparam int COORD_BITS      = 10;
	localparam int ATAN_ITERATIONS = 14;

	localparam int POS_BITS     = COORD_BITS + 1;
	localparam int SQ_BITS      = 2 * POS_BITS;
	localparam int METRIC_BITS  = 2 * POS_BITS;
	localparam int SUM_BITS     = METRIC_BITS + 1;
	localparam int ERR_BITS     = POS_BITS + 1;
	localparam int CENTER_BITS  = 10;
	localparam int FOCAL_BITS   = 12;
	localparam int TIMEOUT_BITS = 16;
	localparam int TIME_BITS    = 32;
	localparam int ANGLE_BITS   = 15;
	localparam int STATUS_BITS  = 2;
	localparam int OP_BITS      = 2;

	// apb side
	localparam int DATA_BITS    = 32;
	localparam int ADDR_BITS    = 5;
	localparam int REG_IDX_BITS = ADDR_BITS - 2;

	// cordic sizing: magnitude bits plus guard, gain and sign headroom
	localparam int TABLE_LEN    = 20;
	localparam int GUARD        = 16;
	localparam int MAG_BITS     = (FOCAL_BITS > ERR_BITS) ? FOCAL_BITS : ERR_BITS;
	localparam int CORDIC_BITS  = GUARD + MAG_BITS + 3;
	localparam int Z_BITS       = 24;
	localparam int CNT_BITS     = $clog2(TABLE_LEN + 1);
	localparam int STEPS_INT    = (ATAN_ITERATIONS < TABLE_LEN) ? ATAN_ITERATIONS : TABLE_LEN;
	localparam logic [CNT_BITS-1:0] CORDIC_STEPS = CNT_BITS'(STEPS_INT);

	localparam logic [ANGLE_BITS-1:0] ANGLE_LIMIT = 15'd12868;

	// atan(2^-i) in Q20
	localparam logic [Z_BITS-1:0] ATAN_Q20 [TABLE_LEN] = '{
		24'd823550, 24'd486170, 24'd256879, 24'd130396, 24'd65451,
		24'd32757,  24'd16383,  24'd8192,   24'd4096,   24'd2048,
		24'd1024,   24'd512,    24'd256,    24'd128,    24'd64,
		24'd32,     24'd16,     24'd8,      24'd4,      24'd2
	};

	// item operations
	localparam logic [OP_BITS-1:0] OP_CAND  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_EMPTY = 2'd1;
	localparam logic [OP_BITS-1:0] OP_START = 2'd2;
	localparam logic [OP_BITS-1:0] OP_STOP  = 2'd3;

	// result status
	localparam logic [STATUS_BITS-1:0] ST_NONE    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NEW     = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_TIMEOUT = 2'd2;

	// register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_FOCAL    = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_MODE     = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_TIMEOUT  = 3'd4;

	typedef struct packed {
		logic [CENTER_BITS-1:0]  center_x;
		logic [CENTER_BITS-1:0]  center_y;
		logic [FOCAL_BITS-1:0]   focal_length;
		logic                    selection_mode;
		logic [TIMEOUT_BITS-1:0] timeout_span;
	} ptt_cfg_t;

	typedef struct packed {
		logic                       start;
		logic signed [ERR_BITS-1:0] err;
		logic [FOCAL_BITS-1:0]      focal;
	} ptt_cordic_req_t;

	typedef struct packed {
		logic                         done;
		logic signed [ANGLE_BITS-1:0] angle;
	} ptt_cordic_rsp_t;

endpackage

### hw/rtl/ptt_if.sv
// ptt_item_if and ptt_result_if: valid/ready channels of the tracker
// depends on ptt_pkg for field widths
interface ptt_item_if;
	import ptt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_BITS-1:0]    op;
	logic [COORD_BITS-1:0] rect_left;
	logic [COORD_BITS-1:0] rect_top;
	logic [COORD_BITS-1:0] rect_width;
	logic [COORD_BITS-1:0] rect_height;
	logic                  last;
	logic [TIME_BITS-1:0]  now_ms;

	modport source (output valid, op, rect_left, rect_top, rect_width, rect_height, last,
		now_ms, input ready);
	modport sink (input valid, op, rect_left, rect_top, rect_width, rect_height, last,
		now_ms, output ready);
endinterface

interface ptt_result_if;
	import ptt_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] pan_angle;
	logic signed [ANGLE_BITS-1:0] tilt_angle;
	logic [STATUS_BITS-1:0]       status;
	logic                         tracking;

	modport source (output valid, pan_angle, tilt_angle, status, tracking, input ready);
	modport sink (input valid, pan_angle, tilt_angle, status, tracking, output ready);
endinterface

### hw/rtl/pan_tilt_target_tracker_top.sv
// Pan/tilt target tracker, top level.
// Depends on ptt_pkg, ptt_if, ptt_regs and ptt_cordic.
//
// Usage: detection rectangles stream in on the item channel, one per transfer,
// with op = candidate; last = 1 on a candidate, or an empty-frame item, closes
// the frame. Start and stop items arm and disarm tracking and give no result.
// Each frame close gives exactly one transfer on the result channel: pan and
// tilt angles in q13 radians, the status and the tracking flag.
// Configuration goes through the apb port (center, focal length, first pick
// rule, timeout); the user writes it only while the block is idle; not enforced.
// Flow: one item is worked on at a time and item.ready is low meanwhile. A
// started candidate goes through accept, two squares on the shared multiplier
// and a compare. A frame close with a new track runs the shared cordic unit
// twice, pan then tilt, each run ending early when its error is zero; a close
// without a new track goes straight from the close state to the output state.
// Reset (arst_n low) clears tracking state and loads the register defaults.
// The result sits in an output register; while the receiver stalls the block
// keeps taking items and only waits when a second result is ready to go out.
module pan_tilt_target_tracker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptt_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ptt_pkg::DATA_BITS-1:0] pwdata,
	output logic [ptt_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	ptt_item_if.sink                      item,
	ptt_result_if.source                  result
);
	import ptt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SQ_A  = 3'd1;
	localparam logic [2:0] S_SQ_B  = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_CLOSE = 3'd4;
	localparam logic [2:0] S_PAN   = 3'd5;
	localparam logic [2:0] S_TILT  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	ptt_cfg_t        cfg;
	ptt_cordic_req_t creq;
	ptt_cordic_rsp_t crsp;

	logic [2:0] state_q;

	// tracking state
	logic                   started_q, tracking_q, has_pick_q;
	logic [METRIC_BITS-1:0] best_q;
	logic [POS_BITS-1:0]    pick_x_q, pick_y_q, target_x_q, target_y_q;
	logic [TIME_BITS-1:0]   last_seen_q;

	// current item
	logic [POS_BITS-1:0]   mx_q, my_q;
	logic [COORD_BITS-1:0] w_q, h_q;
	logic                  last_q;
	logic [TIME_BITS-1:0]  now_q;

	// datapath
	logic [SQ_BITS-1:0]     sq_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [POS_BITS-1:0]    ref_x, ref_y, op_a;
	logic [SQ_BITS-1:0]     prod;
	logic [METRIC_BITS-1:0] metric;
	logic                   use_w, better, accept, timed_out, load_out;
	logic [POS_BITS-1:0]    mid_x, mid_y;

	logic signed [ANGLE_BITS-1:0] pan_q, tilt_q;
	logic [STATUS_BITS-1:0]       status_q;

	logic                         out_valid_q;
	logic signed [ANGLE_BITS-1:0] res_pan_q, res_tilt_q;
	logic [STATUS_BITS-1:0]       res_status_q;
	logic                         res_tracking_q;

	function automatic logic [POS_BITS-1:0] absdiff(input logic [POS_BITS-1:0] a,
		input logic [POS_BITS-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	ptt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	assign mid_x = POS_BITS'(item.rect_left) + POS_BITS'(item.rect_width[COORD_BITS-1:1]);
	assign mid_y = POS_BITS'(item.rect_top) + POS_BITS'(item.rect_height[COORD_BITS-1:1]);

	// first pick by size only when not tracking and in largest-diagonal mode
	assign use_w = !tracking_q && !cfg.selection_mode;
	assign ref_x = tracking_q ? target_x_q : POS_BITS'(cfg.center_x);
	assign ref_y = tracking_q ? target_y_q : POS_BITS'(cfg.center_y);

	// one shared squarer: x term in S_SQ_A, y term in S_SQ_B
	always_comb begin
		if (state_q == S_SQ_A) begin
			op_a = use_w ? POS_BITS'(w_q) : absdiff(mx_q, ref_x);
		end else begin
			op_a = use_w ? POS_BITS'(h_q) : absdiff(my_q, ref_y);
		end
	end
	assign prod = SQ_BITS'(op_a) * SQ_BITS'(op_a);

	assign metric = sum_q[SUM_BITS-1] ? '1 : sum_q[METRIC_BITS-1:0];
	assign better = use_w ? (metric > best_q) : (metric < best_q);

	assign timed_out = {1'b0, now_q} > ((TIME_BITS+1)'(last_seen_q) +
		(TIME_BITS+1)'(cfg.timeout_span));

	// pan is launched from the close cycle, tilt right when pan finishes
	always_comb begin
		creq.start = ((state_q == S_CLOSE) && started_q && has_pick_q) ||
			((state_q == S_PAN) && crsp.done);
		creq.focal = cfg.focal_length;
		if (state_q == S_CLOSE) begin
			creq.err = $signed(ERR_BITS'(cfg.center_x)) - $signed(ERR_BITS'(pick_x_q));
		end else begin
			creq.err = $signed(ERR_BITS'(cfg.center_y)) - $signed(ERR_BITS'(target_y_q));
		end
	end

	assign load_out = (state_q == S_OUT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			tracking_q  <= 1'b0;
			has_pick_q  <= 1'b0;
			best_q      <= '0;
			pick_x_q    <= '0;
			pick_y_q    <= '0;
			target_x_q  <= '0;
			target_y_q  <= '0;
			last_seen_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.op)
							OP_CAND: begin
								if (started_q) begin
									state_q <= S_SQ_A;
								end else if (item.last) begin
									state_q <= S_CLOSE;
								end
							end
							OP_EMPTY: state_q <= S_CLOSE;
							OP_START: begin
								started_q  <= 1'b1;
								tracking_q <= 1'b0;
								has_pick_q <= 1'b0;
								best_q     <= '0;
							end
							OP_STOP: begin
								started_q  <= 1'b0;
								tracking_q <= 1'b0;
								has_pick_q <= 1'b0;
								best_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SQ_A: state_q <= S_SQ_B;
				S_SQ_B: state_q <= S_CMP;
				S_CMP: begin
					if (!has_pick_q || better) begin
						has_pick_q <= 1'b1;
						best_q     <= metric;
						pick_x_q   <= mx_q;
						pick_y_q   <= my_q;
					end
					state_q <= last_q ? S_CLOSE : S_IDLE;
				end
				S_CLOSE: begin
					has_pick_q <= 1'b0;
					best_q     <= '0;
					if (started_q && has_pick_q) begin
						tracking_q  <= 1'b1;
						target_x_q  <= pick_x_q;
						target_y_q  <= pick_y_q;
						last_seen_q <= now_q;
						state_q     <= S_PAN;
					end else begin
						if (started_q && tracking_q && timed_out) begin
							started_q  <= 1'b0;
							tracking_q <= 1'b0;
						end
						state_q <= S_OUT;
					end
				end
				S_PAN: begin
					if (crsp.done) begin
						state_q <= S_TILT;
					end
				end
				S_TILT: begin
					if (crsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item fields and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q   <= mid_x;
			my_q   <= mid_y;
			w_q    <= item.rect_width;
			h_q    <= item.rect_height;
			last_q <= item.last;
			now_q  <= item.now_ms;
		end
		if (state_q == S_SQ_A) begin
			sq_q <= prod;
		end
		if (state_q == S_SQ_B) begin
			sum_q <= SUM_BITS'(sq_q) + SUM_BITS'(prod);
		end
		if (state_q == S_CLOSE) begin
			pan_q  <= '0;
			tilt_q <= '0;
			if (started_q && has_pick_q) begin
				status_q <= ST_NEW;
			end else if (started_q && tracking_q && timed_out) begin
				status_q <= ST_TIMEOUT;
			end else begin
				status_q <= ST_NONE;
			end
		end
		if (state_q == S_PAN && crsp.done) begin
			pan_q <= crsp.angle;
		end
		if (state_q == S_TILT && crsp.done) begin
			tilt_q <= crsp.angle;
		end
		if (load_out) begin
			res_pan_q      <= pan_q;
			res_tilt_q     <= tilt_q;
			res_status_q   <= status_q;
			res_tracking_q <= tracking_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.pan_angle  = res_pan_q;
	assign result.tilt_angle = res_tilt_q;
	assign result.status     = res_status_q;
	assign result.tracking   = res_tracking_q;

endmodule

### hw/rtl/ptt_regs.sv
// ptt_regs: apb configuration registers of the tracker
// depends on ptt_pkg
module ptt_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ptt_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ptt_pkg::DATA_BITS-1:0] pwdata,
	output logic [ptt_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output ptt_pkg::ptt_cfg_t             cfg
);
	import ptt_pkg::*;

	ptt_cfg_t                cfg_q;
	logic [REG_IDX_BITS-1:0] idx;
	logic                    wr;

	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x       <= 10'd320;
			cfg_q.center_y       <= 10'd240;
			cfg_q.focal_length   <= 12'd500;
			cfg_q.selection_mode <= 1'b0;
			cfg_q.timeout_span   <= 16'd1000;
		end else if (wr) begin
			unique case (idx)
				REG_CENTER_X: cfg_q.center_x       <= pwdata[CENTER_BITS-1:0];
				REG_CENTER_Y: cfg_q.center_y       <= pwdata[CENTER_BITS-1:0];
				REG_FOCAL:    cfg_q.focal_length   <= pwdata[FOCAL_BITS-1:0];
				REG_MODE:     cfg_q.selection_mode <= pwdata[0];
				REG_TIMEOUT:  cfg_q.timeout_span   <= pwdata[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_X: prdata = DATA_BITS'(cfg_q.center_x);
			REG_CENTER_Y: prdata = DATA_BITS'(cfg_q.center_y);
			REG_FOCAL:    prdata = DATA_BITS'(cfg_q.focal_length);
			REG_MODE:     prdata = DATA_BITS'(cfg_q.selection_mode);
			REG_TIMEOUT:  prdata = DATA_BITS'(cfg_q.timeout_span);
			default:      prdata = '0;
		endcase
	end

endmodule

### hw/rtl/ptt_cordic.sv
// ptt_cordic: iterative cordic vectoring unit, one rotation per cycle
// depends on ptt_pkg; returns atan(|err| / focal) in q13 with the sign of err
module ptt_cordic (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ptt_pkg::ptt_cordic_req_t req,
	output ptt_pkg::ptt_cordic_rsp_t rsp
);
	import ptt_pkg::*;

	logic signed [CORDIC_BITS-1:0] x_q, y_q, dx, dy;
	logic signed [Z_BITS-1:0]      z_q;
	logic [CNT_BITS-1:0]           iter_q;
	logic                          busy_q, zero_q, neg_q, done_q;
	logic signed [ANGLE_BITS-1:0]  angle_q;
	logic [ERR_BITS-1:0]           mag;
	logic [FOCAL_BITS-1:0]         focal_eff;
	logic [Z_BITS-1:0]             z_pos, z_rnd;
	logic [Z_BITS-8:0]             q;
	logic [ANGLE_BITS-1:0]         q_sat;
	logic signed [ANGLE_BITS-1:0]  angle_fin;

	assign mag       = req.err[ERR_BITS-1] ? $unsigned(-req.err) : $unsigned(req.err);
	assign focal_eff = (req.focal == '0) ? FOCAL_BITS'(1) : req.focal;

	// floor shifts of the current vector
	assign dx = x_q >>> iter_q;
	assign dy = y_q >>> iter_q;

	// clamp at zero, round q20 to q13, clamp to the angle limit
	assign z_pos     = z_q[Z_BITS-1] ? '0 : $unsigned(z_q);
	assign z_rnd     = z_pos + Z_BITS'(64);
	assign q         = z_rnd[Z_BITS-1:7];
	assign q_sat     = (q > (Z_BITS-7)'(ANGLE_LIMIT)) ? ANGLE_LIMIT : q[ANGLE_BITS-1:0];
	assign angle_fin = neg_q ? -$signed(q_sat) : $signed(q_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (zero_q || iter_q == CORDIC_STEPS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					iter_q <= iter_q + CNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORDIC_BITS'({focal_eff, {GUARD{1'b0}}});
			y_q    <= CORDIC_BITS'({mag, {GUARD{1'b0}}});
			z_q    <= '0;
			zero_q <= (mag == '0);
			neg_q  <= req.err[ERR_BITS-1];
		end else if (busy_q) begin
			if (zero_q) begin
				angle_q <= '0;
			end else if (iter_q == CORDIC_STEPS) begin
				angle_q <= angle_fin;
			end else if (y_q > 0) begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + $signed(ATAN_Q20[iter_q]);
			end else begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - $signed(ATAN_Q20[iter_q]);
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.angle = angle_q;

endmodule

### hw/rtl/ptt_checker.sv
// ptt_checker: port-level assertions on the tracker result channel
// depends on ptt_pkg; bound to pan_tilt_target_tracker_top at the end of this file
module ptt_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [ptt_pkg::ANGLE_BITS-1:0] pan_angle,
	input logic signed [ptt_pkg::ANGLE_BITS-1:0] tilt_angle,
	input logic [ptt_pkg::STATUS_BITS-1:0]       status,
	input logic                                  tracking
);
	import ptt_pkg::*;

	// a timeout always ends tracking
	a_timeout_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TIMEOUT |-> !tracking)
		else $error("timeout result with tracking still set");

	// a new track always leaves the block tracking
	a_new_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NEW |-> tracking)
		else $error("new track result without tracking");

	// angles are only reported with a new track
	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_NEW |-> pan_angle == 0 && tilt_angle == 0)
		else $error("nonzero angle without a new track");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pan_angle) &&
		$stable(tilt_angle) && $stable(status) && $stable(tracking))
		else $error("stalled result changed");

endmodule

bind pan_tilt_target_tracker_top ptt_checker u_ptt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.pan_angle  (result.pan_angle),
	.tilt_angle (result.tilt_angle),
	.status     (result.status),
	.tracking   (result.tracking)
);

### sim/ptt_track_checker.sv
`timescale 1ns / 1ps
// ptt_track_checker: watches the item, result and apb channels of the tracker,
// predicts every frame-close report and compares it field by field
// depends on ptt_pkg and the ptt_item_if / ptt_result_if interfaces
module ptt_track_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [ptt_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ptt_pkg::DATA_BITS-1:0] pwdata,
	ptt_item_if                           item,
	ptt_result_if                         result,
	output int                            fails,
	output int                            waiting
);
	import ptt_pkg::*;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] pan;
		logic signed [ANGLE_BITS-1:0] tilt;
		logic [STATUS_BITS-1:0]       status;
		logic                         tracking;
	} aim_report_t;

	localparam longint METRIC_CAP = (longint'(1) << METRIC_BITS) - 1;
	localparam longint ANGLE_CAP  = 12868;
	localparam int     ATAN_STEPS = (ATAN_ITERATIONS < 20) ? ATAN_ITERATIONS : 20;

	// atan(2^-i), q20 radians
	localparam longint ATAN_TAB [20] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
	};

	aim_report_t report_q [$];

	logic [CENTER_BITS-1:0]  cx, cy;
	logic [FOCAL_BITS-1:0]   focal;
	logic                    mode;
	logic [TIMEOUT_BITS-1:0] span;

	logic                    armed, locked, have_pick;
	logic [METRIC_BITS-1:0]  pick_score;
	logic [POS_BITS-1:0]     cand_x, cand_y, aim_x, aim_y;
	logic [TIME_BITS-1:0]    seen_ms;

	function automatic logic signed [ANGLE_BITS-1:0] q13_atan(input int err,
		input int unsigned f);
		longint x, y, z, dx, dy, q, mag;
		logic negative;
		negative = err < 0;
		mag = negative ? -longint'(err) : longint'(err);
		if (f == 0)
			f = 1;
		if (mag == 0)
			return '0;
		x = longint'(f) <<< 16;
		y = mag <<< 16;
		z = 0;
		// vectoring toward y = 0, floor shifts on signed values
		for (int i = 0; i < ATAN_STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y > 0) begin
				x += dy;
				y -= dx;
				z += ATAN_TAB[i];
			end else begin
				x -= dy;
				y += dx;
				z -= ATAN_TAB[i];
			end
		end
		if (z < 0)
			z = 0;
		q = (z + 64) >>> 7;
		if (q > ANGLE_CAP)
			q = ANGLE_CAP;
		return ANGLE_BITS'(negative ? -q : q);
	endfunction

	function automatic logic [METRIC_BITS-1:0] sat_dist(input int ax, input int ay,
		input int bx, input int by);
		longint dx, dy, d;
		dx = ax - bx;
		dy = ay - by;
		d = dx * dx + dy * dy;
		return (d > METRIC_CAP) ? METRIC_BITS'(METRIC_CAP) : METRIC_BITS'(d);
	endfunction

	task automatic drop_track();
		armed = 1'b0;
		locked = 1'b0;
		have_pick = 1'b0;
		pick_score = '0;
	endtask

	task automatic consider_rect(input logic [COORD_BITS-1:0] l, input logic [COORD_BITS-1:0] t,
		input logic [COORD_BITS-1:0] w, input logic [COORD_BITS-1:0] h);
		logic [POS_BITS-1:0]    mx, my;
		logic [METRIC_BITS-1:0] m;
		logic                   better;
		mx = POS_BITS'(l) + POS_BITS'(w >> 1);
		my = POS_BITS'(t) + POS_BITS'(h >> 1);
		if (!armed)
			return;
		if (locked) begin
			m = sat_dist(int'(mx), int'(my), int'(aim_x), int'(aim_y));
			better = m < pick_score;
		end else if (mode == 1'b0) begin
			m = METRIC_BITS'(int'(w) * int'(w) + int'(h) * int'(h));
			better = m > pick_score;
		end else begin
			m = sat_dist(int'(mx), int'(my), int'(cx), int'(cy));
			better = m < pick_score;
		end
		// ties keep the earlier rectangle
		if (!have_pick || better) begin
			have_pick = 1'b1;
			pick_score = m;
			cand_x = mx;
			cand_y = my;
		end
	endtask

	task automatic close_frame(input logic [TIME_BITS-1:0] now);
		aim_report_t r;
		r = '0;
		r.status = ST_NONE;
		if (armed) begin
			if (have_pick) begin
				locked = 1'b1;
				aim_x = cand_x;
				aim_y = cand_y;
				seen_ms = now;
				r.pan = q13_atan(int'(cx) - int'(aim_x), 32'(focal));
				r.tilt = q13_atan(int'(cy) - int'(aim_y), 32'(focal));
				r.status = ST_NEW;
			end else if (locked && longint'(now) > longint'(seen_ms) + longint'(span)) begin
				// deadline sum has no wrap
				armed = 1'b0;
				locked = 1'b0;
				r.status = ST_TIMEOUT;
			end
		end
		have_pick = 1'b0;
		pick_score = '0;
		r.tracking = locked;
		report_q.push_back(r);
	endtask

	task automatic check_report();
		aim_report_t e;
		if (report_q.size() == 0) begin
			$error("unexpected result: pan_angle %0d tilt_angle %0d status %0d tracking %0d",
				result.pan_angle, result.tilt_angle, result.status, result.tracking);
			fails++;
		end else begin
			e = report_q.pop_front();
			if (result.pan_angle !== e.pan) begin
				$error("pan_angle: expected %0d, got %0d", e.pan, result.pan_angle);
				fails++;
			end
			if (result.tilt_angle !== e.tilt) begin
				$error("tilt_angle: expected %0d, got %0d", e.tilt, result.tilt_angle);
				fails++;
			end
			if (result.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, result.status);
				fails++;
			end
			if (result.tracking !== e.tracking) begin
				$error("tracking: expected %0d, got %0d", e.tracking, result.tracking);
				fails++;
			end
		end
	endtask

	task automatic apply_write(input logic [REG_IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] d);
		case (idx)
			REG_CENTER_X: cx = d[CENTER_BITS-1:0];
			REG_CENTER_Y: cy = d[CENTER_BITS-1:0];
			REG_FOCAL:    focal = d[FOCAL_BITS-1:0];
			REG_MODE:     mode = d[0];
			REG_TIMEOUT:  span = d[TIMEOUT_BITS-1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx = 10'd320;
			cy = 10'd240;
			focal = 12'd500;
			mode = 1'b0;
			span = 16'd1000;
			drop_track();
			cand_x = '0;
			cand_y = '0;
			aim_x = '0;
			aim_y = '0;
			seen_ms = '0;
			report_q.delete();
			fails = 0;
			waiting = 0;
		end else begin
			if (result.valid && result.ready)
				check_report();
			if (psel && penable && pwrite && pready)
				apply_write(paddr[ADDR_BITS-1:2], pwdata);
			if (item.valid && item.ready) begin
				case (item.op)
					OP_CAND: begin
						consider_rect(item.rect_left, item.rect_top, item.rect_width,
							item.rect_height);
						if (item.last)
							close_frame(item.now_ms);
					end
					OP_EMPTY: close_frame(item.now_ms);
					OP_START: begin
						drop_track();
						armed = 1'b1;
					end
					default: drop_track();
				endcase
			end
			waiting = report_q.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives detection frames and register settings into the tracker
// depends on ptt_pkg, ptt_if, the tracker rtl and ptt_track_checker
module testbench;
	import ptt_pkg::*;

	typedef struct packed {
		logic [OP_BITS-1:0]    op;
		logic [COORD_BITS-1:0] l;
		logic [COORD_BITS-1:0] t;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
		logic                  last;
		logic [TIME_BITS-1:0]  now;
	} det_item_t;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_WAIT  = 40;
	localparam int DRAIN_CYCLES = 60;
	localparam int TOTAL_ITEMS  = 1550;
	localparam int CALM_ITEMS   = 150;
	localparam int PHASES       = 6;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel, penable, pwrite, pready;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata, prdata;

	ptt_item_if   tx ();
	ptt_result_if rx ();

	int fails, waiting;
	int sent = 0;
	int fluent = 0;
	int hold_cnt = 0;
	int stall_cnt = 0;
	bit calm = 1'b0;

	logic [TIME_BITS-1:0]    clock_ms = '0;
	logic [TIMEOUT_BITS-1:0] span_now = 16'd1000;
	logic [COORD_BITS-1:0]   anchor_l = '0, anchor_t = '0, anchor_w = '0, anchor_h = '0;

	pan_tilt_target_tracker_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (tx),
		.result  (rx)
	);

	ptt_track_checker scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.item    (tx),
		.result  (rx),
		.fails   (fails),
		.waiting (waiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stall bursts, some long stretches of ready
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!calm && $urandom_range(0, 99) < 20) begin
			rx.ready <= 1'b0;
			hold_cnt <= $urandom_range(0, 16);
		end else begin
			rx.ready <= 1'b1;
			if ($urandom_range(0, 99) < 4)
				hold_cnt <= $urandom_range(30, 120);
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cnt <= 0;
		end else if ((tx.valid && tx.ready) || (rx.valid && rx.ready) || (psel && penable)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	task automatic send_item(input det_item_t it);
		@(negedge clk);
		if (fluent > 0) begin
			fluent--;
		end else if (!calm && $urandom_range(0, 99) < 12) begin
			tx.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end else if (!calm && $urandom_range(0, 99) < 3) begin
			fluent = $urandom_range(30, 80);
		end
		tx.valid <= 1'b1;
		tx.op <= it.op;
		tx.rect_left <= it.l;
		tx.rect_top <= it.t;
		tx.rect_width <= it.w;
		tx.rect_height <= it.h;
		tx.last <= it.last;
		tx.now_ms <= it.now;
		@(posedge clk);
		while (!tx.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic cand(input logic [COORD_BITS-1:0] l, input logic [COORD_BITS-1:0] t,
		input logic [COORD_BITS-1:0] w, input logic [COORD_BITS-1:0] h, input logic lst);
		send_item('{op: OP_CAND, l: l, t: t, w: w, h: h, last: lst,
			now: lst ? clock_ms : $urandom()});
	endtask

	task automatic control(input logic [OP_BITS-1:0] op);
		send_item('{op: op, l: COORD_BITS'($urandom()), t: COORD_BITS'($urandom()),
			w: COORD_BITS'($urandom()), h: COORD_BITS'($urandom()),
			last: 1'($urandom_range(0, 1)), now: $urandom()});
	endtask

	task automatic close_empty();
		send_item('{op: OP_EMPTY, l: COORD_BITS'($urandom()), t: COORD_BITS'($urandom()),
			w: COORD_BITS'($urandom()), h: COORD_BITS'($urandom()),
			last: 1'($urandom_range(0, 1)), now: clock_ms});
	endtask

	task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// block idle: every report in, plus time for a start or stop still in flight
	task automatic settle();
		@(negedge clk);
		tx.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [CENTER_BITS-1:0] cx, input logic [CENTER_BITS-1:0] cy,
		input logic [FOCAL_BITS-1:0] f, input logic m, input logic [TIMEOUT_BITS-1:0] s);
		reg_write(REG_CENTER_X, DATA_BITS'(cx));
		reg_write(REG_CENTER_Y, DATA_BITS'(cy));
		reg_write(REG_FOCAL, DATA_BITS'(f));
		reg_write(REG_MODE, DATA_BITS'(m));
		reg_write(REG_TIMEOUT, DATA_BITS'(s));
		span_now = s;
	endtask

	task automatic random_traffic(input int upto);
		int r, k;
		logic open, lst;
		logic [COORD_BITS-1:0] l, t, w, h;
		while (sent < upto) begin
			r = $urandom_range(0, 99);
			if (r < 7) begin
				control(OP_START);
			end else if (r < 9) begin
				control(OP_STOP);
			end else if (r < 14) begin
				// noise: any op, any fields, sometimes a jump in time
				if ($urandom_range(0, 3) == 0)
					clock_ms = $urandom();
				send_item('{op: OP_BITS'($urandom_range(0, 3)), l: COORD_BITS'($urandom()),
					t: COORD_BITS'($urandom()), w: COORD_BITS'($urandom()),
					h: COORD_BITS'($urandom()), last: 1'($urandom_range(0, 1)),
					now: clock_ms});
			end else if (r < 24) begin
				// empty frame, often right at the timeout boundary
				if ($urandom_range(0, 2) == 0)
					clock_ms = clock_ms + TIME_BITS'(span_now) + TIME_BITS'($urandom_range(0, 2))
						- 32'd1;
				else
					clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 60));
				close_empty();
			end else begin
				k = $urandom_range(1, 4);
				open = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 3) == 0) begin
					anchor_l = COORD_BITS'($urandom());
					anchor_t = COORD_BITS'($urandom());
					anchor_w = COORD_BITS'($urandom());
					anchor_h = COORD_BITS'($urandom());
				end
				clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 60));
				for (int j = 0; j < k; j++) begin
					if ($urandom_range(0, 1) == 0) begin
						l = COORD_BITS'($urandom());
						t = COORD_BITS'($urandom());
						w = COORD_BITS'($urandom());
						h = COORD_BITS'($urandom());
					end else begin
						// near the anchor: close compares and ties
						l = anchor_l ^ COORD_BITS'($urandom_range(0, 7));
						t = anchor_t ^ COORD_BITS'($urandom_range(0, 7));
						w = anchor_w ^ COORD_BITS'($urandom_range(0, 7));
						h = anchor_h ^ COORD_BITS'($urandom_range(0, 7));
					end
					lst = (j == k - 1) && !open;
					cand(l, t, w, h, lst);
				end
			end
		end
	endtask

	initial begin
		int base, upto;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx.valid = 1'b0;
		tx.op = OP_CAND;
		tx.rect_left = '0;
		tx.rect_top = '0;
		tx.rect_width = '0;
		tx.rect_height = '0;
		tx.last = 1'b0;
		tx.now_ms = '0;
		rx.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// not started: candidate ignored, frame ends still answer
		clock_ms = 32'd50;
		cand(10'd5, 10'd5, 10'd5, 10'd5, 1'b1);
		close_empty();
		control(OP_START);
		// equal diagonals: the earlier rectangle stays
		cand(10'd0, 10'd0, 10'd0, 10'd2, 1'b0);
		cand(10'd0, 10'd0, 10'd0, 10'd0, 1'b0);
		clock_ms = 32'd100;
		cand(10'd1023, 10'd1023, 10'd2, 10'd0, 1'b1);
		// tracking: saturated distance first, then a tie on the nearest
		cand(10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0);
		cand(10'd10, 10'd0, 10'd0, 10'd0, 1'b0);
		cand(10'd0, 10'd20, 10'd0, 10'd0, 1'b0);
		clock_ms = 32'd200;
		cand(10'd10, 10'd2, 10'd0, 10'd0, 1'b1);
		// timeout boundary: equal keeps tracking, one more stops it
		clock_ms = 32'd1200;
		close_empty();
		clock_ms = 32'd1201;
		close_empty();
		// stop drops an open pick
		control(OP_START);
		cand(10'd100, 10'd100, 10'd50, 10'd50, 1'b0);
		control(OP_STOP);
		close_empty();
		// empty frame end closes an open frame; deadline sum must not wrap
		control(OP_START);
		cand(10'd300, 10'd200, 10'd40, 10'd40, 1'b0);
		clock_ms = 32'hFFFF_FF00;
		close_empty();
		clock_ms = 32'hFFFF_FFFF;
		close_empty();
		// first pick rule changed in the middle of a frame
		control(OP_START);
		cand(10'd0, 10'd0, 10'd100, 10'd100, 1'b0);
		settle();
		reg_write(REG_MODE, 32'd1);
		cand(10'd300, 10'd220, 10'd40, 10'd40, 1'b0);
		cand(10'd0, 10'd0, 10'd0, 10'd0, 1'b1);
		// zero focal length, far target, zero timeout
		settle();
		apply_setting(10'd0, 10'd0, 12'd0, 1'b1, 16'd0);
		cand(10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1);
		clock_ms = clock_ms + 32'd1;
		close_empty();

		base = sent;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: apply_setting(10'd320, 10'd240, 12'd500, 1'b0, 16'd1000);
				1: apply_setting(10'd0, 10'd0, 12'd1, 1'b1, 16'd0);
				2: apply_setting(10'd1023, 10'd1023, 12'd4095, 1'b0, 16'd65535);
				3: apply_setting(CENTER_BITS'($urandom()), CENTER_BITS'($urandom()),
					FOCAL_BITS'($urandom_range(1, 4095)), 1'($urandom_range(0, 1)),
					TIMEOUT_BITS'($urandom_range(0, 3000)));
				4: apply_setting(10'd512, 10'd384, FOCAL_BITS'($urandom_range(1, 50)), 1'b1,
					TIMEOUT_BITS'($urandom_range(0, 200)));
				default: apply_setting(CENTER_BITS'($urandom()), CENTER_BITS'($urandom()),
					FOCAL_BITS'($urandom()), 1'($urandom()), TIMEOUT_BITS'($urandom()));
			endcase
			upto = base + (TOTAL_ITEMS - base) * (p + 1) / PHASES;
			if (p == PHASES - 1) begin
				random_traffic(upto - CALM_ITEMS);
				calm = 1'b1;
				fluent = 0;
			end
			random_traffic(upto);
		end

		@(negedge clk);
		tx.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0 && waiting == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
